FILE: hw/rtl/b64lw_pkg.sv
// Types, character constants and the symbol table for the line-wrapping base64 encoder.
// No dependencies; every other file in hw/rtl uses this package.
package b64lw_pkg;

   localparam logic [7:0] CHAR_PAD       = 8'h3D;
   localparam logic [7:0] CHAR_NL        = 8'h0A;
   localparam logic [7:0] LINE_LIMIT_RST = 8'd72;
   localparam int         REC_CHARS      = 5;
   localparam logic [2:0] GROUP_CHARS    = 3'd4;
   localparam logic [2:0] WRAP_CHARS     = 3'd5;

   localparam logic [1:0] PHASE_EMPTY = 2'd0;
   localparam logic [1:0] PHASE_ONE   = 2'd1;
   localparam logic [1:0] PHASE_TWO   = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } rsp_type;

   typedef struct packed {
      logic [REC_CHARS-1:0][7:0] chars;
      logic [2:0]                cnt;
      logic                      last;
   } rec_type;

   function automatic logic [7:0] sym(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26) begin
         return w + 8'h41;
      end else if (v < 6'd52) begin
         return w + 8'h47;
      end else if (v < 6'd62) begin
         return w - 8'd4;
      end else if (v == 6'd62) begin
         return 8'h2B;
      end else begin
         return 8'h2F;
      end
   endfunction

endpackage

FILE: hw/rtl/b64lw_encode.sv
// Group assembly, line counter and line-limit register of the base64 encoder.
// Builds one record of four or five characters per emitting beat; uses b64lw_pkg.
module b64lw_encode (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  b64lw_pkg::req_type req_data,
   input  logic              slot_free,
   output logic              rec_load,
   output b64lw_pkg::rec_type rec
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic [8:0] line_count_ff, line_count_in;
   logic [7:0] line_limit_ff;

   logic [1:0] ph;
   logic [7:0] b;
   logic       fin;
   logic       emits;
   logic       accept;
   logic [8:0] lc_sum;
   logic       wrap;
   logic [7:0] g0, g1, g2, g3;

   always_comb begin
      ph     = (phase_ff > b64lw_pkg::PHASE_TWO) ? b64lw_pkg::PHASE_EMPTY : phase_ff;
      b      = req_data.data_byte;
      fin    = req_data.final_byte;
      lc_sum = line_count_ff + 9'd4;
      wrap   = lc_sum >= {1'b0, line_limit_ff};
      g0     = b64lw_pkg::sym(held0_ff[7:2]);
      g1     = b64lw_pkg::sym({held0_ff[1:0], held1_ff[7:4]});
      g2     = b64lw_pkg::sym({held1_ff[3:0], b[7:6]});
      g3     = b64lw_pkg::sym(b[5:0]);

      phase_in      = phase_ff;
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      line_count_in = line_count_ff;
      emits         = 1'b0;
      rec.chars     = '0;
      rec.cnt       = b64lw_pkg::WRAP_CHARS;
      rec.last      = 1'b0;

      case ({fin, ph})
         {1'b0, b64lw_pkg::PHASE_EMPTY}: begin
            held0_in = b;
            phase_in = b64lw_pkg::PHASE_ONE;
         end
         {1'b0, b64lw_pkg::PHASE_ONE}: begin
            held1_in = b;
            phase_in = b64lw_pkg::PHASE_TWO;
         end
         {1'b0, b64lw_pkg::PHASE_TWO}: begin
            emits         = 1'b1;
            rec.chars     = {b64lw_pkg::CHAR_NL, g3, g2, g1, g0};
            rec.cnt       = wrap ? b64lw_pkg::WRAP_CHARS : b64lw_pkg::GROUP_CHARS;
            line_count_in = wrap ? 9'd0 : lc_sum;
            phase_in      = b64lw_pkg::PHASE_EMPTY;
         end
         {1'b1, b64lw_pkg::PHASE_TWO}: begin
            emits     = 1'b1;
            rec.chars = {b64lw_pkg::CHAR_NL, g3, g2, g1, g0};
            rec.last  = 1'b1;
         end
         {1'b1, b64lw_pkg::PHASE_ONE}: begin
            emits     = 1'b1;
            rec.chars = {b64lw_pkg::CHAR_NL, b64lw_pkg::CHAR_PAD,
                         b64lw_pkg::sym({b[3:0], 2'b00}),
                         b64lw_pkg::sym({held0_ff[1:0], b[7:4]}),
                         b64lw_pkg::sym(held0_ff[7:2])};
            rec.last  = 1'b1;
         end
         {1'b1, b64lw_pkg::PHASE_EMPTY}: begin
            emits     = 1'b1;
            rec.chars = {b64lw_pkg::CHAR_NL, b64lw_pkg::CHAR_PAD, b64lw_pkg::CHAR_PAD,
                         b64lw_pkg::sym({b[1:0], 4'b0000}),
                         b64lw_pkg::sym(b[7:2])};
            rec.last  = 1'b1;
         end
         default: begin
            emits = 1'b0;
         end
      endcase

      if (fin) begin
         phase_in      = b64lw_pkg::PHASE_EMPTY;
         held0_in      = 8'd0;
         held1_in      = 8'd0;
         line_count_in = 9'd0;
      end

      req_ready = slot_free || !emits;
      accept    = req_valid && req_ready;
      rec_load  = accept && emits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= b64lw_pkg::PHASE_EMPTY;
         held0_ff      <= 8'd0;
         held1_ff      <= 8'd0;
         line_count_ff <= 9'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         held0_ff      <= held0_in;
         held1_ff      <= held1_in;
         line_count_ff <= line_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff <= b64lw_pkg::LINE_LIMIT_RST;
      end else if (csr_we) begin
         line_limit_ff <= csr_wdata;
      end
   end

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3) else $error("group phase out of range");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      line_count_ff <= 9'd258) else $error("line count beyond bound");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      line_count_ff[1:0] == 2'b00) else $error("line count not a whole number of groups");

endmodule

FILE: hw/rtl/b64lw_serialize.sv
// Record register and character sequencer of the base64 encoder: one character a beat.
// Uses b64lw_pkg for the record and response types.
module b64lw_serialize (
   input  logic               clock,
   input  logic               reset,
   input  logic               rec_load,
   input  b64lw_pkg::rec_type rec_in,
   output logic               slot_free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output b64lw_pkg::rsp_type rsp_data
);

   b64lw_pkg::rec_type rec_ff;
   logic               valid_ff;
   logic [2:0]         idx_ff;
   logic               at_end;

   always_comb begin
      at_end             = idx_ff == (rec_ff.cnt - 3'd1);
      rsp_valid          = valid_ff;
      rsp_data.out_char  = rec_ff.chars[idx_ff];
      rsp_data.last_char = rec_ff.last && at_end;
      slot_free          = !valid_ff || (rsp_ready && at_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else if (rec_load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 3'd0;
      end else if (valid_ff && rsp_ready) begin
         if (at_end) begin
            valid_ff <= 1'b0;
            idx_ff   <= 3'd0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rec_load) begin
         rec_ff <= rec_in;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff < rec_ff.cnt) else $error("character index past record");

   a_cnt_legal: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (rec_ff.cnt == b64lw_pkg::GROUP_CHARS ||
                    rec_ff.cnt == b64lw_pkg::WRAP_CHARS)) else $error("bad record length");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rec_load |-> slot_free) else $error("record overwritten before drained");

   a_last_nl: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_data.last_char) |-> rsp_data.out_char == b64lw_pkg::CHAR_NL)
      else $error("message does not end in newline");

endmodule

FILE: hw/rtl/base64_encoder_line_wrap.sv
// Base64 encoder with line wrapping: one raw byte per req beat in, one ASCII character
// per rsp beat out. A byte that only fills the group is accepted even while
// characters are still draining; a byte that completes a group or ends the message
// loads a record of four or five characters, sent one per cycle while rsp_ready is high
// from the record register through the single character port. The line limit written
// through csr_ takes effect on the next group.
module base64_encoder_line_wrap (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [7:0]         csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  b64lw_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output b64lw_pkg::rsp_type rsp_data
);

   b64lw_pkg::rec_type rec;
   logic               rec_load;
   logic               slot_free;

   b64lw_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .slot_free (slot_free),
      .rec_load  (rec_load),
      .rec       (rec)
   );

   b64lw_serialize u_serialize (
      .clock     (clock),
      .reset     (reset),
      .rec_load  (rec_load),
      .rec_in    (rec),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/b64_char_checker.sv
// Scoreboard for the line-wrapping base64 encoder: predicts every character from the
// accepted byte beats and the line limit, and compares the rsp beats against it.
// Depends on b64lw_pkg for the beat types, phase codes and character constants.
module b64_char_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [7:0]         csr_wdata,
   input  logic               req_valid,
   input  logic               req_ready,
   input  b64lw_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  b64lw_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 outstanding
);

   localparam logic [511:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic [7:0]         wrap_limit;
   logic [1:0]         group_fill;
   logic [7:0]         held_first;
   logic [7:0]         held_second;
   logic [8:0]         chars_on_line;
   b64lw_pkg::rsp_type expected_chars[$];
   int                 mismatches;

   function automatic logic [7:0] symbol_of(input logic [5:0] v);
      return ALPHABET[8*(63-v) +: 8];
   endfunction

   task automatic push_char(input logic [7:0] c, input logic fin);
      b64lw_pkg::rsp_type e;
      e.out_char  = c;
      e.last_char = fin;
      expected_chars.push_back(e);
   endtask

   task automatic push_group(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
      push_char(symbol_of(a[7:2]), 1'b0);
      push_char(symbol_of({a[1:0], b[7:4]}), 1'b0);
      push_char(symbol_of({b[3:0], c[7:6]}), 1'b0);
      push_char(symbol_of(c[5:0]), 1'b0);
   endtask

   task automatic predict_beat(input b64lw_pkg::req_type beat);
      logic [7:0] b;
      b = beat.data_byte;
      if (!beat.final_byte) begin
         if (group_fill != b64lw_pkg::PHASE_TWO) begin
            if (group_fill == b64lw_pkg::PHASE_EMPTY) begin
               held_first = b;
            end else begin
               held_second = b;
            end
            group_fill = group_fill + 2'd1;
         end else begin
            push_group(held_first, held_second, b);
            group_fill    = b64lw_pkg::PHASE_EMPTY;
            chars_on_line = chars_on_line + 9'd4;
            if (chars_on_line >= {1'b0, wrap_limit}) begin
               push_char(b64lw_pkg::CHAR_NL, 1'b0);
               chars_on_line = '0;
            end
         end
      end else begin
         case (group_fill)
            b64lw_pkg::PHASE_TWO: begin
               push_group(held_first, held_second, b);
            end
            b64lw_pkg::PHASE_ONE: begin
               push_char(symbol_of(held_first[7:2]), 1'b0);
               push_char(symbol_of({held_first[1:0], b[7:4]}), 1'b0);
               push_char(symbol_of({b[3:0], 2'b00}), 1'b0);
               push_char(b64lw_pkg::CHAR_PAD, 1'b0);
            end
            default: begin
               push_char(symbol_of(b[7:2]), 1'b0);
               push_char(symbol_of({b[1:0], 4'b0000}), 1'b0);
               push_char(b64lw_pkg::CHAR_PAD, 1'b0);
               push_char(b64lw_pkg::CHAR_PAD, 1'b0);
            end
         endcase
         push_char(b64lw_pkg::CHAR_NL, 1'b1);
         group_fill    = b64lw_pkg::PHASE_EMPTY;
         held_first    = '0;
         held_second   = '0;
         chars_on_line = '0;
      end
   endtask

   always @(posedge clock) begin
      b64lw_pkg::rsp_type want;
      b64lw_pkg::rsp_type got;
      if (reset) begin
         wrap_limit    = b64lw_pkg::LINE_LIMIT_RST;
         group_fill    = b64lw_pkg::PHASE_EMPTY;
         held_first    = '0;
         held_second   = '0;
         chars_on_line = '0;
         expected_chars.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_chars.size() == 0) begin
               $error("out_char %h (last_char %b) arrived with nothing expected",
                      got.out_char, got.last_char);
               mismatches++;
            end else begin
               want = expected_chars.pop_front();
               if (got.out_char !== want.out_char) begin
                  $error("out_char: expected %h, got %h", want.out_char, got.out_char);
                  mismatches++;
               end
               if (got.last_char !== want.last_char) begin
                  $error("last_char: expected %b, got %b", want.last_char, got.last_char);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_beat(req_data);
         end
         if (csr_we) begin
            wrap_limit = csr_wdata;
         end
      end
      fail_count  <= mismatches;
      outstanding <= expected_chars.size();
   end

endmodule

FILE: tb/testbench.sv
// Top of the encoder testbench: clock, reset, byte stimulus, line-limit writes and
// rsp back-pressure; the verdict comes from the failure and outstanding counts of b64_char_checker.
// Depends on b64lw_pkg, base64_encoder_line_wrap and b64_char_checker.
module testbench;

   localparam int DRAIN_CYCLES = 12;
   localparam int LONG_HOLD    = 200;
   localparam int TOTAL_BEATS  = 300;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               csr_we    = 1'b0;
   logic [7:0]         csr_wdata = b64lw_pkg::LINE_LIMIT_RST;
   logic               req_valid = 1'b0;
   b64lw_pkg::req_type req_data  = '0;
   logic               rsp_ready = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   b64lw_pkg::rsp_type rsp_data;

   int   fail_count;
   int   outstanding;
   int   beats_sent = 0;
   int   hold_asks  = 0;
   logic steady     = 1'b0;

   always #4 clock = ~clock;

   base64_encoder_line_wrap uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   b64_char_checker char_check (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 25);
   endfunction

   function automatic int msg_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return $urandom_range(1, 6);
      end else if (r < 88) begin
         return $urandom_range(7, 30);
      end
      return $urandom_range(31, 90);
   endfunction

   function automatic logic [7:0] pick_limit(input int phase);
      int r;
      case (phase)
         0: return 8'd255;
         1: return 8'd0;
         2: return 8'd3;
         3: return 8'd4;
         default: begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               return 8'($urandom_range(0, 3));
            end else if (r < 70) begin
               return 8'($urandom_range(4, 40));
            end
            return 8'($urandom_range(41, 255));
         end
      endcase
   endfunction

   task automatic send_beat(input logic [7:0] data, input logic fin);
      b64lw_pkg::req_type beat;
      int                 gap;
      beat.data_byte  = data;
      beat.final_byte = fin;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      gap = steady ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_message(input int len, input logic leave_open);
      for (int i = 0; i < len; i++) begin
         send_beat(8'($urandom_range(0, 255)), (i == len - 1) && !leave_open);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : receiver
      int len;
      int holds_done;
      holds_done = 0;
      @(posedge clock);
      forever begin
         if (hold_asks != holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            len = steady ? 0 : idle_len();
            if (len > 0) begin
               rsp_ready <= 1'b0;
               repeat (len) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int phase_end;
      phase = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'h7F, 1'b0);
      send_beat(8'h01, 1'b1);
      wait_drained();
      write_limit(8'd4);
      for (int i = 0; i < 6; i++) begin
         send_beat(8'(i * 43), 1'b0);
      end
      send_beat(8'hA5, 1'b1);
      wait_drained();

      while (beats_sent < TOTAL_BEATS) begin
         write_limit(pick_limit(phase));
         steady <= (phase == 4);
         if (phase == 2) begin
            hold_asks <= hold_asks + 1;
         end
         phase_end = beats_sent + $urandom_range(25, 45);
         while (beats_sent < phase_end) begin
            send_message(msg_len(), 1'b0);
         end
         if (phase == 0 || $urandom_range(0, 1) == 1) begin
            send_message($urandom_range(1, 9), 1'b1);
         end
         wait_drained();
         phase++;
      end

      send_beat(8'($urandom_range(0, 255)), 1'b1);
      wait_drained();
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
